@@ src/saturation_brightness_adjust_assert.svh @@
// assertion macros for the saturation and brightness adjust block
// used by the top level only, needs signals clock and reset in scope
`ifndef SATURATION_BRIGHTNESS_ADJUST_ASSERT_SVH
`define SATURATION_BRIGHTNESS_ADJUST_ASSERT_SVH

// same-cycle implication
`define SBADJ_ASSERT_NOW(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error("sbadj assertion failed");

// next-cycle implication
`define SBADJ_ASSERT_NEXT(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error("sbadj assertion failed");

`endif

@@ src/sbadj_pkg.sv @@
// shared types and constants for the saturation and brightness adjust block
// no dependencies
package sbadj_pkg;

   localparam int CHANNEL_BITS    = 16;
   localparam int GAIN_BITS       = 16;
   localparam int GAIN_FRAC_BITS  = 12;
   localparam int HUE_FRAC_BITS   = 16;
   localparam int STEPS_PER_STAGE = 4;
   localparam int DIV_ITERS       = (HUE_FRAC_BITS > CHANNEL_BITS) ? HUE_FRAC_BITS
                                                                   : CHANNEL_BITS;
   localparam int POS_BITS        = HUE_FRAC_BITS + 3;
   localparam int ADDR_BITS       = 3;

   localparam logic [CHANNEL_BITS-1:0] CH_ONE   = '1;
   localparam logic [GAIN_BITS-1:0]    GAIN_ONE = GAIN_BITS'(1 << GAIN_FRAC_BITS);

   localparam logic REG_SAT_GAIN    = 1'b0;
   localparam logic REG_BRIGHT_GAIN = 1'b1;

   localparam logic [2:0] SEC_RED     = 3'd0;
   localparam logic [2:0] SEC_YELLOW  = 3'd1;
   localparam logic [2:0] SEC_GREEN   = 3'd2;
   localparam logic [2:0] SEC_CYAN    = 3'd3;
   localparam logic [2:0] SEC_BLUE    = 3'd4;

   typedef enum logic [2:0] {
      BASE_R_UP,
      BASE_R_DOWN,
      BASE_G_UP,
      BASE_G_DOWN,
      BASE_B_UP,
      BASE_B_DOWN
   } hue_base_type;

   typedef struct packed {
      logic [CHANNEL_BITS-1:0] red_in;
      logic [CHANNEL_BITS-1:0] green_in;
      logic [CHANNEL_BITS-1:0] blue_in;
   } pixel_type;

   typedef struct packed {
      logic [CHANNEL_BITS-1:0] red_out;
      logic [CHANNEL_BITS-1:0] green_out;
      logic [CHANNEL_BITS-1:0] blue_out;
   } result_type;

   typedef struct packed {
      logic [CHANNEL_BITS-1:0] mx;
      logic [CHANNEL_BITS-1:0] delta;
      hue_base_type            base;
      logic                    gray;
      logic                    hue_full;
      logic                    sat_full;
   } side_type;

   typedef struct packed {
      logic [CHANNEL_BITS-1:0] hue_num;
      logic [CHANNEL_BITS-1:0] sat_num;
      side_type                side;
   } front_type;

endpackage

@@ src/sbadj_div.sv @@
// pipelined restoring divider, up to STEPS quotient bits per stage
// depends on sbadj_pkg; numerator must be below the divisor
module sbadj_div #(
   parameter int WIDTH  = sbadj_pkg::CHANNEL_BITS,
   parameter int ITERS  = sbadj_pkg::DIV_ITERS,
   parameter int STEPS  = sbadj_pkg::STEPS_PER_STAGE,
   parameter int STAGES = (sbadj_pkg::DIV_ITERS + sbadj_pkg::STEPS_PER_STAGE - 1)
                          / sbadj_pkg::STEPS_PER_STAGE
) (
   input  logic             clock,
   input  logic             advance,
   input  logic [WIDTH-1:0] num_in,
   input  logic [WIDTH-1:0] den_in,
   output logic [ITERS-1:0] quo_out,
   output logic [WIDTH-1:0] rem_out
);
   import sbadj_pkg::*;

   logic [WIDTH-1:0] rem_ff [STAGES];
   logic [WIDTH-1:0] rem_in [STAGES];
   logic [ITERS-1:0] quo_ff [STAGES];
   logic [ITERS-1:0] quo_in [STAGES];
   logic [WIDTH-1:0] den_ff [STAGES];
   logic [WIDTH-1:0] src_rem [STAGES];
   logic [ITERS-1:0] src_quo [STAGES];
   logic [WIDTH-1:0] src_den [STAGES];

   for (genvar j = 0; j < STAGES; j++) begin : g_stage
      if (j == 0) begin : g_first
         assign src_rem[j] = num_in;
         assign src_quo[j] = '0;
         assign src_den[j] = den_in;
      end else begin : g_next
         assign src_rem[j] = rem_ff[j-1];
         assign src_quo[j] = quo_ff[j-1];
         assign src_den[j] = den_ff[j-1];
      end

      always_comb begin
         logic [WIDTH:0]   wide;
         logic [WIDTH-1:0] r;
         logic [ITERS-1:0] q;
         r = src_rem[j];
         q = src_quo[j];
         for (int s = 0; s < STEPS; s++) begin
            if (j * STEPS + s < ITERS) begin
               wide = {r, 1'b0};
               if (wide >= {1'b0, src_den[j]}) begin
                  wide = wide - {1'b0, src_den[j]};
                  q = {q[ITERS-2:0], 1'b1};
               end else begin
                  q = {q[ITERS-2:0], 1'b0};
               end
               r = wide[WIDTH-1:0];
            end
         end
         rem_in[j] = r;
         quo_in[j] = q;
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[j] <= rem_in[j];
            quo_ff[j] <= quo_in[j];
            den_ff[j] <= src_den[j];
         end
      end
   end

   assign quo_out = quo_ff[STAGES-1];
   assign rem_out = rem_ff[STAGES-1];

endmodule

@@ src/sbadj_front.sv @@
// first stage: max, min, chroma spread, hue and saturation numerator selection
// depends on sbadj_pkg
module sbadj_front (
   input  logic                  clock,
   input  logic                  advance,
   input  sbadj_pkg::pixel_type  req_data,
   output sbadj_pkg::front_type  front_out
);
   import sbadj_pkg::*;

   front_type front_ff;
   front_type front_in;

   always_comb begin
      logic [CHANNEL_BITS-1:0] r;
      logic [CHANNEL_BITS-1:0] g;
      logic [CHANNEL_BITS-1:0] b;
      logic [CHANNEL_BITS-1:0] mx;
      logic [CHANNEL_BITS-1:0] mn;
      logic [CHANNEL_BITS-1:0] n;
      logic [CHANNEL_BITS-1:0] delta;
      r = req_data.red_in;
      g = req_data.green_in;
      b = req_data.blue_in;
      mn = r;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      if (r >= g && r >= b) begin
         mx = r;
         if (g >= b) begin
            front_in.side.base = BASE_R_UP;
            n = g - b;
         end else begin
            front_in.side.base = BASE_R_DOWN;
            n = b - g;
         end
      end else if (g >= b) begin
         mx = g;
         if (b >= r) begin
            front_in.side.base = BASE_G_UP;
            n = b - r;
         end else begin
            front_in.side.base = BASE_G_DOWN;
            n = r - b;
         end
      end else begin
         mx = b;
         if (r >= g) begin
            front_in.side.base = BASE_B_UP;
            n = r - g;
         end else begin
            front_in.side.base = BASE_B_DOWN;
            n = g - r;
         end
      end
      delta = mx - mn;
      front_in.side.mx       = mx;
      front_in.side.delta    = delta;
      front_in.side.gray     = (delta == '0);
      front_in.side.hue_full = (n == delta);
      front_in.side.sat_full = (delta == mx);
      front_in.hue_num       = (n == delta) ? '0 : n;
      front_in.sat_num       = (delta == mx) ? '0 : delta;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         front_ff <= front_in;
      end
   end

   assign front_out = front_ff;

endmodule

@@ src/sbadj_back.sv @@
// hue and saturation finish, gains, back conversion to rgb and clamping
// depends on sbadj_pkg; six register stages
module sbadj_back (
   input  logic                                  clock,
   input  logic                                  advance,
   input  sbadj_pkg::side_type                   side,
   input  logic [sbadj_pkg::HUE_FRAC_BITS-1:0]   hue_quo,
   input  logic [sbadj_pkg::CHANNEL_BITS-1:0]    sat_quo,
   input  logic [sbadj_pkg::CHANNEL_BITS-1:0]    sat_rem,
   input  logic [sbadj_pkg::GAIN_BITS-1:0]       sat_gain,
   input  logic [sbadj_pkg::GAIN_BITS-1:0]       bright_gain,
   output sbadj_pkg::result_type                 rsp_data
);
   import sbadj_pkg::*;

   localparam int CB = CHANNEL_BITS;
   localparam int HF = HUE_FRAC_BITS;
   localparam int PW = CB + GAIN_BITS - GAIN_FRAC_BITS;
   localparam logic [POS_BITS-1:0] HUE_ONE = POS_BITS'(1 << HF);
   localparam logic [POS_BITS-1:0] HUE_TWO = POS_BITS'(2 << HF);
   localparam logic [POS_BITS-1:0] HUE_FOUR = POS_BITS'(4 << HF);
   localparam logic [POS_BITS-1:0] HUE_SIX = POS_BITS'(6 << HF);

   // stage 1
   logic [2:0]    sect1_ff, sect1_in;
   logic [HF-1:0] frac1_ff, frac1_in;
   logic [CB-1:0] sat1_ff, sat1_in;
   logic [CB-1:0] val1_ff;
   // stage 2
   logic [2:0]    sect2_ff;
   logic [HF-1:0] frac2_ff;
   logic [CB-1:0] sat2_ff, sat2_in;
   logic [CB-1:0] val2_ff, val2_in;
   // stage 3
   logic [2:0]      sect3_ff;
   logic [HF-1:0]   frac3_ff;
   logic [CB-1:0]   val3_ff;
   logic [2*CB-1:0] prod3_ff;
   // stage 4
   logic [2:0]    sect4_ff;
   logic [HF-1:0] frac4_ff;
   logic [CB-1:0] val4_ff;
   logic [CB-1:0] c4_ff, c4_in;
   // stage 5
   logic [2:0]    sect5_ff;
   logic [CB-1:0] c5_ff;
   logic [CB-1:0] x5_ff, x5_in;
   logic [CB-1:0] m5_ff;
   // stage 6
   result_type    out_ff, out_in;

   always_comb begin
      logic [POS_BITS-1:0] q;
      logic [POS_BITS-1:0] pos;
      q = side.hue_full ? HUE_ONE : POS_BITS'(hue_quo);
      unique case (side.base)
         BASE_R_UP:   pos = q;
         BASE_R_DOWN: pos = HUE_SIX - q;
         BASE_G_UP:   pos = HUE_TWO + q;
         BASE_G_DOWN: pos = HUE_TWO - q;
         BASE_B_UP:   pos = HUE_FOUR + q;
         BASE_B_DOWN: pos = HUE_FOUR - q;
         default:     pos = '0;
      endcase
      if (pos >= HUE_SIX) pos = pos - HUE_SIX;
      if (side.gray) pos = '0;
      sect1_in = pos[POS_BITS-1:HF];
      frac1_in = pos[HF-1:0];
      if (side.gray) begin
         sat1_in = '0;
      end else if (side.sat_full) begin
         sat1_in = CH_ONE;
      end else if (sat_rem >= side.delta) begin
         sat1_in = sat_quo;
      end else begin
         sat1_in = sat_quo - CB'(1);
      end
   end

   always_comb begin
      logic [CB+GAIN_BITS-1:0] sp;
      logic [CB+GAIN_BITS-1:0] vp;
      logic [PW-1:0]           ss;
      logic [PW-1:0]           vs;
      sp = (CB+GAIN_BITS)'(sat1_ff) * (CB+GAIN_BITS)'(sat_gain);
      vp = (CB+GAIN_BITS)'(val1_ff) * (CB+GAIN_BITS)'(bright_gain);
      ss = sp[CB+GAIN_BITS-1:GAIN_FRAC_BITS];
      vs = vp[CB+GAIN_BITS-1:GAIN_FRAC_BITS];
      sat2_in = (ss > PW'(CH_ONE)) ? CH_ONE : ss[CB-1:0];
      val2_in = (vs > PW'(CH_ONE)) ? CH_ONE : vs[CB-1:0];
   end

   // divide by all ones: (p + (p >> CB) + 1) >> CB
   always_comb begin
      logic [2*CB:0] sum;
      sum = (2*CB+1)'(prod3_ff) + (2*CB+1)'(prod3_ff[2*CB-1:CB]) + (2*CB+1)'(1);
      c4_in = sum[2*CB-1:CB];
   end

   always_comb begin
      logic [HF:0]      mulf;
      logic [CB+HF:0]   xp;
      mulf = sect4_ff[0] ? ((HF+1)'(1 << HF) - (HF+1)'(frac4_ff)) : (HF+1)'(frac4_ff);
      xp = (CB+HF+1)'(c4_ff) * (CB+HF+1)'(mulf);
      x5_in = xp[CB+HF-1:HF];
   end

   always_comb begin
      logic [CB-1:0] ro;
      logic [CB-1:0] go;
      logic [CB-1:0] bo;
      logic [CB:0]   rs;
      logic [CB:0]   gs;
      logic [CB:0]   bs;
      case (sect5_ff)
         SEC_RED:    begin ro = c5_ff; go = x5_ff; bo = '0;    end
         SEC_YELLOW: begin ro = x5_ff; go = c5_ff; bo = '0;    end
         SEC_GREEN:  begin ro = '0;    go = c5_ff; bo = x5_ff; end
         SEC_CYAN:   begin ro = '0;    go = x5_ff; bo = c5_ff; end
         SEC_BLUE:   begin ro = x5_ff; go = '0;    bo = c5_ff; end
         default:    begin ro = c5_ff; go = '0;    bo = x5_ff; end
      endcase
      rs = (CB+1)'(ro) + (CB+1)'(m5_ff);
      gs = (CB+1)'(go) + (CB+1)'(m5_ff);
      bs = (CB+1)'(bo) + (CB+1)'(m5_ff);
      out_in.red_out   = rs[CB] ? CH_ONE : rs[CB-1:0];
      out_in.green_out = gs[CB] ? CH_ONE : gs[CB-1:0];
      out_in.blue_out  = bs[CB] ? CH_ONE : bs[CB-1:0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sect1_ff <= sect1_in;
         frac1_ff <= frac1_in;
         sat1_ff  <= sat1_in;
         val1_ff  <= side.mx;
         sect2_ff <= sect1_ff;
         frac2_ff <= frac1_ff;
         sat2_ff  <= sat2_in;
         val2_ff  <= val2_in;
         sect3_ff <= sect2_ff;
         frac3_ff <= frac2_ff;
         val3_ff  <= val2_ff;
         prod3_ff <= (2*CB)'(val2_ff) * (2*CB)'(sat2_ff);
         sect4_ff <= sect3_ff;
         frac4_ff <= frac3_ff;
         val4_ff  <= val3_ff;
         c4_ff    <= c4_in;
         sect5_ff <= sect4_ff;
         c5_ff    <= c4_ff;
         x5_ff    <= x5_in;
         m5_ff    <= val4_ff - c4_ff;
         out_ff   <= out_in;
      end
   end

   assign rsp_data = out_ff;

endmodule

@@ src/saturation_brightness_adjust.sv @@
// hsv saturation and brightness adjust, one item per cycle
// stages: the front stage, then the two pipelined dividers for hue and saturation
// at DIV_STEPS bits per stage, then the back stages
// throughput: one item per cycle while rsp_ready is high; a stall holds all stages
// reset: synchronous, clears the valid bits and sets both gains to 1.0
module saturation_brightness_adjust #(
   parameter int DIV_STEPS = sbadj_pkg::STEPS_PER_STAGE
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  sbadj_pkg::pixel_type                req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output sbadj_pkg::result_type               rsp_data,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [sbadj_pkg::ADDR_BITS-1:0]     paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);
   import sbadj_pkg::*;

   `include "saturation_brightness_adjust_assert.svh"

   localparam int DIV_STAGES = (DIV_ITERS + DIV_STEPS - 1) / DIV_STEPS;
   localparam int LAT        = DIV_STAGES + 7;

   logic [GAIN_BITS-1:0] sat_gain_ff, sat_gain_in;
   logic [GAIN_BITS-1:0] bright_gain_ff, bright_gain_in;
   logic [LAT-1:0]       valid_ff, valid_in;
   logic                 advance;
   front_type            front;
   side_type             side_ff [DIV_STAGES];
   logic [HUE_FRAC_BITS-1:0] hue_quo;
   logic [CHANNEL_BITS-1:0]  sat_quo;
   logic [CHANNEL_BITS-1:0]  sat_rem;

   assign advance   = !valid_ff[LAT-1] || rsp_ready;
   assign req_ready = advance;
   assign rsp_valid = valid_ff[LAT-1];
   assign pready    = 1'b1;

   always_comb begin
      sat_gain_in    = sat_gain_ff;
      bright_gain_in = bright_gain_ff;
      if (psel && penable && pwrite) begin
         unique case (paddr[2])
            REG_SAT_GAIN:    sat_gain_in    = pwdata[GAIN_BITS-1:0];
            REG_BRIGHT_GAIN: bright_gain_in = pwdata[GAIN_BITS-1:0];
            default:         sat_gain_in    = sat_gain_ff;
         endcase
      end
      unique case (paddr[2])
         REG_SAT_GAIN:    prdata = 32'(sat_gain_ff);
         REG_BRIGHT_GAIN: prdata = 32'(bright_gain_ff);
         default:         prdata = '0;
      endcase
      valid_in = {valid_ff[LAT-2:0], req_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sat_gain_ff    <= GAIN_ONE;
         bright_gain_ff <= GAIN_ONE;
         valid_ff       <= '0;
      end else begin
         sat_gain_ff    <= sat_gain_in;
         bright_gain_ff <= bright_gain_in;
         if (advance) begin
            valid_ff <= valid_in;
         end
      end
   end

   sbadj_front u_front (
      .clock     (clock),
      .advance   (advance),
      .req_data  (req_data),
      .front_out (front)
   );

   sbadj_div #(
      .WIDTH  (CHANNEL_BITS),
      .ITERS  (HUE_FRAC_BITS),
      .STEPS  (DIV_STEPS),
      .STAGES (DIV_STAGES)
   ) u_hue_div (
      .clock   (clock),
      .advance (advance),
      .num_in  (front.hue_num),
      .den_in  (front.side.delta),
      .quo_out (hue_quo),
      .rem_out ()
   );

   sbadj_div #(
      .WIDTH  (CHANNEL_BITS),
      .ITERS  (CHANNEL_BITS),
      .STEPS  (DIV_STEPS),
      .STAGES (DIV_STAGES)
   ) u_sat_div (
      .clock   (clock),
      .advance (advance),
      .num_in  (front.sat_num),
      .den_in  (front.side.mx),
      .quo_out (sat_quo),
      .rem_out (sat_rem)
   );

   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff[0] <= front.side;
         for (int i = 1; i < DIV_STAGES; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   sbadj_back u_back (
      .clock       (clock),
      .advance     (advance),
      .side        (side_ff[DIV_STAGES-1]),
      .hue_quo     (hue_quo),
      .sat_quo     (sat_quo),
      .sat_rem     (sat_rem),
      .sat_gain    (sat_gain_ff),
      .bright_gain (bright_gain_ff),
      .rsp_data    (rsp_data)
   );

   `SBADJ_ASSERT_NEXT(a_accept_enters, req_valid && req_ready, valid_ff[0])
   `SBADJ_ASSERT_NEXT(a_stall_holds, !advance, $stable(valid_ff))
   `SBADJ_ASSERT_NOW(a_rsp_from_pipe, $rose(rsp_valid), $past(valid_ff[LAT-2]))

endmodule
